FILE: rtl/core/trms_pkg.sv
// Package for the tube ring mesh sweep: result kinds, register indexes, queue job type,
// pipeline sideband type and the elaboration-time angle table function.
// No dependencies.
`default_nettype none
package trms_pkg;

  // result kinds
  localparam logic [1:0] KIND_VERT = 2'd0;
  localparam logic [1:0] KIND_TRI  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_SIDES  = 2'd0;
  localparam logic [1:0] REG_RADIUS = 2'd1;
  localparam logic [1:0] REG_FACING = 2'd2;

  localparam int VC_W    = 17;
  localparam int Q_DEPTH = 2;

  // offset scaling: Q28 * mm / 4096000 = Q16.16 metres, 4096000 = 2^15 * 125
  localparam logic [31:0] HALF_DIV   = 32'd2048000;
  localparam logic [31:0] RECIP_125  = 32'd2199023255;  // floor(2^38 / 125)
  localparam int          RECIP_SH   = 38;
  localparam logic [63:0] Q30_ONE    = 64'd1073741824;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // one classified frame, front to back
  typedef struct packed {
    logic               err;
    logic [15:0]        base;
    logic [15:0]        prev;
    logic               have_prev;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] binormal_x;
    logic signed [15:0] binormal_y;
    logic signed [15:0] binormal_z;
    logic [31:0]        arc_len;
  } job_t;

  // fields that ride along the vertex pipeline
  typedef struct packed {
    logic        is_vert;
    logic [1:0]  kind;
    logic        last;
    logic [15:0] tri_a;
    logic [31:0] tri_bc;
    logic [31:0] tex_u;
    logic [16:0] tex_v;
  } side_t;

  // cos and sin of one quarter-turn step, Q1.14 unsigned, packed {cos, sin}
  function automatic logic [29:0] angle_entry(input int unsigned rem,
                                              input int unsigned qbits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic [63:0]        s30;
    logic signed [63:0] c30;
    logic [63:0]        cc;
    logic [63:0]        ss;
    x  = (64'(rem) * PI_HALF_Q30) >> qbits;
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    t = Q30_ONE - (((x2 * t) >> 30) / 110);
    t = Q30_ONE - (((x2 * t) >> 30) / 72);
    t = Q30_ONE - (((x2 * t) >> 30) / 42);
    t = Q30_ONE - (((x2 * t) >> 30) / 20);
    t = Q30_ONE - (((x2 * t) >> 30) / 6);
    s30 = (x * t) >> 30;
    t = Q30_ONE;
    t = Q30_ONE - (((x2 * t) >> 30) / 132);
    t = Q30_ONE - (((x2 * t) >> 30) / 90);
    t = Q30_ONE - (((x2 * t) >> 30) / 56);
    t = Q30_ONE - (((x2 * t) >> 30) / 30);
    t = Q30_ONE - (((x2 * t) >> 30) / 12);
    c30 = $signed(Q30_ONE) - $signed(((x2 * t) >> 30) / 2);
    if (c30 < 0) begin
      c30 = 0;
    end
    ss = (s30 + 64'd32768) >> 16;
    cc = (64'(c30) + 64'd32768) >> 16;
    return {cc[14:0], ss[14:0]};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/trms_front.sv
// Front of the tube ring mesh sweep: accepts frames, runs the vertex budget and strip
// bookkeeping, and pushes classified jobs. Depends on trms_pkg.
`default_nettype none
module trms_front #(
  parameter int MAX_VERTICES = 65536
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire signed [31:0]  pos_x,
  input  wire signed [31:0]  pos_y,
  input  wire signed [31:0]  pos_z,
  input  wire signed [15:0]  normal_x,
  input  wire signed [15:0]  normal_y,
  input  wire signed [15:0]  normal_z,
  input  wire signed [15:0]  binormal_x,
  input  wire signed [15:0]  binormal_y,
  input  wire signed [15:0]  binormal_z,
  input  wire        [31:0]  path_distance,
  input  wire                new_mesh,
  input  wire        [4:0]   side_count,
  input  wire                clear_prev,
  input  wire                q_full,
  output logic               q_push,
  output trms_pkg::job_t     q_job
);
  import trms_pkg::*;

  logic [VC_W-1:0] vertex_count;
  logic [15:0]     prev_base;
  logic            have_prev;

  logic [VC_W-1:0] vc0;
  logic [15:0]     pb0;
  logic            hp0;
  logic [VC_W:0]   need;
  logic            over;
  logic            acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign q_push   = acc;

  // apply new_mesh, then check the budget
  always_comb begin
    vc0  = new_mesh ? '0 : vertex_count;
    pb0  = new_mesh ? '0 : prev_base;
    hp0  = new_mesh ? 1'b0 : have_prev;
    need = {1'b0, vc0} + (VC_W+1)'(side_count) + (VC_W+1)'(1);
    over = need > (VC_W+1)'(MAX_VERTICES);
    q_job.err        = over;
    q_job.base       = vc0[15:0];
    q_job.prev       = pb0;
    q_job.have_prev  = hp0;
    q_job.pos_x      = pos_x;
    q_job.pos_y      = pos_y;
    q_job.pos_z      = pos_z;
    q_job.normal_x   = normal_x;
    q_job.normal_y   = normal_y;
    q_job.normal_z   = normal_z;
    q_job.binormal_x = binormal_x;
    q_job.binormal_y = binormal_y;
    q_job.binormal_z = binormal_z;
    q_job.arc_len    = path_distance;
  end

  // advance strip state per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      prev_base    <= '0;
      have_prev    <= 1'b0;
    end else begin
      if (acc) begin
        if (over) begin
          vertex_count <= vc0;
          prev_base    <= pb0;
          have_prev    <= hp0;
        end else begin
          vertex_count <= need[VC_W-1:0];
          prev_base    <= vc0[15:0];
          have_prev    <= 1'b1;
        end
      end
      if (clear_prev) begin
        have_prev <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/trms_queue.sv
// Short job queue between front and back of the tube ring mesh sweep.
// Depends on trms_pkg.
`default_nettype none
module trms_queue (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  trms_pkg::job_t  push_job,
  output logic            full,
  input  wire             pop,
  output trms_pkg::job_t  head,
  output logic            not_empty
);
  import trms_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  job_t          mem [Q_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] cnt;

  assign full      = cnt == CW'(Q_DEPTH);
  assign not_empty = cnt != '0;
  assign head      = mem[rp];

  // store on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_job;
    end
  end

  // move pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + PW'(1);
      end
      if (pop) begin
        rp <= rp + PW'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + CW'(1);
      end else if (pop && !push) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(Q_DEPTH)) else $error("queue count beyond depth");

endmodule
`default_nettype wire

FILE: rtl/core/trms_back.sv
// Back of the tube ring mesh sweep: ring sequencer with a serial divider for the per-side
// steps, a vertex pipeline and the output register. Depends on trms_pkg.
`default_nettype none
module trms_back #(
  parameter int ANGLE_TABLE_BITS = 10
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                q_valid,
  input  trms_pkg::job_t     q_job,
  output logic               q_pop,
  input  wire        [4:0]   side_count,
  input  wire        [15:0]  radius_mm,
  input  wire                facing_inward,
  output logic               out_valid,
  input  wire                out_stall,
  output logic       [1:0]   kind,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [15:0] surf_nx,
  output logic signed [15:0] surf_ny,
  output logic signed [15:0] surf_nz,
  output logic       [31:0]  tex_u,
  output logic       [16:0]  tex_v,
  output logic       [15:0]  tri_a,
  output logic       [31:0]  tri_bc,
  output logic               last
);
  import trms_pkg::*;

  localparam int B   = ANGLE_TABLE_BITS;
  localparam int QB  = B - 2;
  localparam int QN  = 1 << QB;
  localparam int DSH = 16 - B;
  localparam int NST = 9;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_VERT = 2'd2;
  localparam logic [1:0] ST_TRI  = 2'd3;

  // quarter-turn cos/sin table
  logic [29:0] ang_tab [QN];
  for (genvar g = 0; g < QN; g++) begin : g_ang
    localparam logic [29:0] ENTRY = angle_entry(g, QB);
    assign ang_tab[g] = ENTRY;
  end

  // sequencer state
  logic [1:0]  st;
  job_t        job;
  logic [4:0]  s_cnt;
  logic        half;
  logic [B-1:0] qa;
  logic [4:0]  ra;
  logic [16:0] qv;
  logic [4:0]  rv;
  logic [16:0] dq;
  logic [4:0]  drem;
  logic [4:0]  rem_a;
  logic [4:0]  dk;
  logic        div_ok;
  logic [4:0]  div_n;

  logic        en;
  logic        issue;
  side_t       sb_i;
  logic [B-1:0] idx_i;

  logic [B-1:0] ka;
  logic [5:0]  ra_sum;
  logic        ra_wrap;
  logic [5:0]  rv_sum;
  logic        rv_wrap;
  logic [5:0]  dnr;
  logic        dge;
  logic [4:0]  drem_next;
  logic [15:0] ta;
  logic [15:0] tan;
  logic [15:0] tb;
  logic [15:0] tbn;

  assign en = !out_valid || !out_stall;
  assign ka = B'(dq >> DSH);

  // incremental side steps and divider step
  always_comb begin
    ra_sum    = {1'b0, ra} + {1'b0, rem_a};
    ra_wrap   = ra_sum >= {1'b0, side_count};
    rv_sum    = {1'b0, rv} + {1'b0, drem};
    rv_wrap   = rv_sum >= {1'b0, side_count};
    dnr       = {drem, dk == 5'd16};
    dge       = dnr >= {1'b0, side_count};
    drem_next = dge ? 5'(dnr - {1'b0, side_count}) : dnr[4:0];
  end

  // issue one result per cycle unless the output stalls
  always_comb begin
    issue = 1'b0;
    sb_i  = '0;
    idx_i = '0;
    ta    = job.prev + 16'(s_cnt);
    tan   = ta + 16'd1;
    tb    = job.base + 16'(s_cnt);
    tbn   = tb + 16'd1;
    unique case (st)
      ST_IDLE: begin
        if (q_valid && en && q_job.err) begin
          issue     = 1'b1;
          sb_i.kind = KIND_ERR;
          sb_i.last = 1'b1;
        end
      end
      ST_VERT: begin
        issue        = en;
        sb_i.is_vert = 1'b1;
        sb_i.kind    = KIND_VERT;
        sb_i.tex_u   = job.arc_len;
        sb_i.tex_v   = qv;
        sb_i.last    = (s_cnt == side_count) && !job.have_prev;
        idx_i        = (s_cnt == side_count) ? '0 : qa;
      end
      ST_TRI: begin
        issue      = en;
        sb_i.kind  = KIND_TRI;
        sb_i.tri_a = ta;
        sb_i.last  = (s_cnt == side_count - 5'd1) && half;
        if (facing_inward) begin
          sb_i.tri_bc = half ? {tbn, tan} : {tb, tbn};
        end else begin
          sb_i.tri_bc = half ? {tan, tbn} : {tbn, tb};
        end
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  assign q_pop = (st == ST_IDLE) && q_valid && en;

  // ring sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= ST_IDLE;
      div_ok <= 1'b0;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (q_pop) begin
            job <= q_job;
            if (!q_job.err) begin
              if (div_ok && div_n == side_count) begin
                st    <= ST_VERT;
                s_cnt <= '0;
                qa    <= '0;
                ra    <= side_count >> 1;
                qv    <= '0;
                rv    <= side_count >> 1;
              end else begin
                st     <= ST_DIV;
                div_ok <= 1'b0;
                dq     <= '0;
                drem   <= '0;
                dk     <= 5'd16;
              end
            end
          end
        end
        ST_DIV: begin
          drem <= drem_next;
          dq   <= {dq[15:0], dge};
          if (dk == 5'(DSH)) begin
            rem_a <= drem_next;
          end
          if (dk == '0) begin
            div_ok <= 1'b1;
            div_n  <= side_count;
            st     <= ST_VERT;
            s_cnt  <= '0;
            qa     <= '0;
            ra     <= side_count >> 1;
            qv     <= '0;
            rv     <= side_count >> 1;
          end else begin
            dk <= dk - 5'd1;
          end
        end
        ST_VERT: begin
          if (en) begin
            ra <= ra_wrap ? 5'(ra_sum - {1'b0, side_count}) : ra_sum[4:0];
            qa <= qa + ka + B'(ra_wrap);
            rv <= rv_wrap ? 5'(rv_sum - {1'b0, side_count}) : rv_sum[4:0];
            qv <= qv + dq + 17'(rv_wrap);
            if (s_cnt == side_count) begin
              s_cnt <= '0;
              half  <= 1'b0;
              st    <= job.have_prev ? ST_TRI : ST_IDLE;
            end else begin
              s_cnt <= s_cnt + 5'd1;
            end
          end
        end
        ST_TRI: begin
          if (en) begin
            half <= ~half;
            if (half) begin
              if (s_cnt == side_count - 5'd1) begin
                st <= ST_IDLE;
              end else begin
                s_cnt <= s_cnt + 5'd1;
              end
            end
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // vertex pipeline registers
  logic               vld  [NST];
  side_t              sb_p [NST];
  logic [95:0]        pos_p [NST];
  logic [B-1:0]       idx0;
  logic [95:0]        nb0;
  logic [95:0]        nb1;
  logic signed [15:0] cos1;
  logic signed [15:0] sin1;
  logic signed [31:0] pn2 [3];
  logic signed [31:0] pb2 [3];
  logic signed [32:0] r3  [3];
  logic [30:0]        mag4 [3];
  logic [46:0]        prod5 [3];
  logic [31:0]        y6 [3];
  logic [63:0]        ym7 [3];
  logic [31:0]        y7 [3];
  logic [25:0]        qh8 [3];
  logic               need8 [3];
  logic               neg_p [4:8][3];
  logic signed [15:0] nv_p  [4:8][3];

  logic [29:0]        ent;
  logic signed [15:0] cu;
  logic signed [15:0] su;
  logic signed [15:0] cos_d;
  logic signed [15:0] sin_d;
  logic signed [15:0] nv_d [3];
  logic signed [31:0] px_d [3];
  logic               need_d [3];
  logic [25:0]        qh7 [3];

  // quadrant fold of the table entry
  always_comb begin
    ent = ang_tab[idx0[QB-1:0]];
    cu  = $signed({1'b0, ent[29:15]});
    su  = $signed({1'b0, ent[14:0]});
    case (idx0[B-1:QB])
      2'd0: begin cos_d = cu;  sin_d = su;  end
      2'd1: begin cos_d = -su; sin_d = cu;  end
      2'd2: begin cos_d = -cu; sin_d = -su; end
      default: begin cos_d = su; sin_d = -cu; end
    endcase
  end

  // normal rounding, correction compare and position saturation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [32:0] rnd;
      logic signed [17:0] nr;
      logic [32:0]        rem;
      logic [25:0]        q;
      logic signed [26:0] off;
      logic signed [33:0] sum;
      rnd = (r3[i] + 33'sd8192) >>> 14;
      nr  = 18'(rnd);
      if (facing_inward) begin
        nr = -nr;
      end
      if (nr > 18'sd32767) begin
        nv_d[i] = 16'sd32767;
      end else if (nr < -18'sd32768) begin
        nv_d[i] = -16'sd32768;
      end else begin
        nv_d[i] = 16'(nr);
      end
      qh7[i]    = 26'(ym7[i] >> RECIP_SH);
      rem       = {1'b0, y7[i]} - 33'(qh7[i]) * 33'd125;
      need_d[i] = rem >= 33'd125;
      q   = qh8[i] + 26'(need8[i]);
      off = neg_p[8][i] ? -$signed({1'b0, q}) : $signed({1'b0, q});
      sum = 34'($signed(pos_p[8][95-32*i -: 32])) + 34'(off);
      if (sum > 34'sd2147483647) begin
        px_d[i] = 32'sh7fffffff;
      end else if (sum < -34'sd2147483648) begin
        px_d[i] = 32'sh80000000;
      end else begin
        px_d[i] = 32'(sum);
      end
    end
  end

  // pipeline valid bits and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) begin
        vld[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= issue;
      for (int k = 1; k < NST; k++) begin
        vld[k] <= vld[k-1];
      end
      out_valid <= vld[NST-1];
    end
  end

  // advance the datapath
  always_ff @(posedge clk) begin
    if (en) begin
      sb_p[0]  <= sb_i;
      idx0     <= idx_i;
      pos_p[0] <= {job.pos_x, job.pos_y, job.pos_z};
      nb0      <= {job.normal_x, job.normal_y, job.normal_z,
                   job.binormal_x, job.binormal_y, job.binormal_z};
      for (int k = 1; k < NST; k++) begin
        sb_p[k]  <= sb_p[k-1];
        pos_p[k] <= pos_p[k-1];
      end
      nb1  <= nb0;
      cos1 <= cos_d;
      sin1 <= sin_d;
      for (int i = 0; i < 3; i++) begin
        pn2[i]     <= $signed(nb1[95-16*i -: 16]) * cos1;
        pb2[i]     <= $signed(nb1[47-16*i -: 16]) * sin1;
        r3[i]      <= 33'(pn2[i]) + 33'(pb2[i]);
        mag4[i]    <= r3[i][32] ? 31'(-r3[i]) : 31'(r3[i]);
        neg_p[4][i] <= r3[i][32];
        nv_p[4][i] <= nv_d[i];
        for (int k = 5; k <= 8; k++) begin
          neg_p[k][i] <= neg_p[k-1][i];
          nv_p[k][i]  <= nv_p[k-1][i];
        end
        prod5[i] <= 47'(mag4[i]) * 47'(radius_mm);
        y6[i]    <= 32'((48'(prod5[i]) + 48'(HALF_DIV)) >> 15);
        ym7[i]   <= 64'(y6[i]) * 64'(RECIP_125);
        y7[i]    <= y6[i];
        qh8[i]   <= qh7[i];
        need8[i] <= need_d[i];
      end
      kind    <= sb_p[8].kind;
      last    <= sb_p[8].last;
      tri_a   <= sb_p[8].tri_a;
      tri_bc  <= sb_p[8].tri_bc;
      tex_u   <= sb_p[8].tex_u;
      tex_v   <= sb_p[8].tex_v;
      out_x   <= sb_p[8].is_vert ? px_d[0] : '0;
      out_y   <= sb_p[8].is_vert ? px_d[1] : '0;
      out_z   <= sb_p[8].is_vert ? px_d[2] : '0;
      surf_nx <= sb_p[8].is_vert ? nv_p[8][0] : '0;
      surf_ny <= sb_p[8].is_vert ? nv_p[8][1] : '0;
      surf_nz <= sb_p[8].is_vert ? nv_p[8][2] : '0;
    end
  end

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_ERR) |-> last) else $error("error result without last");

  a_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (st == ST_DIV) |-> !issue && !q_pop) else $error("issue during divide");

endmodule
`default_nettype wire

FILE: rtl/core/tube_ring_mesh_sweep.sv
// Top level of the tube ring mesh sweep: configuration registers on an APB-style port,
// front, job queue and back. Depends on trms_pkg, trms_front, trms_queue, trms_back.
//
// Use: each input word is one path frame (position, normal, binormal, distance, new_mesh).
// For side count n the block answers with n+1 ring vertices and, after the first ring of
// a strip, 2n triangles joining this ring to the previous one; a ring that would exceed
// the vertex budget is answered with one error word instead. last marks the final word.
// Throughput: the back sequencer emits one result word per cycle unless the receiver
// stalls, and passes through its idle state to pick up the next job. After side_count
// changes, the first ring waits for the serial divider that derives the per-side angle
// and v steps. Each result word passes the queue, the nine-stage vertex pipeline (table,
// products, sum, magnitude, scale, divide by 4096000 through a reciprocal, saturation)
// and the output register.
// A two-entry queue lets frames be accepted while a ring is still being emitted.
// Receiver stall freezes the whole back pipeline; the output word holds until taken.
// Reset empties the queue and pipeline, clears the strip state and loads the register
// reset values: 8 sides, 1000 mm radius, outward facing.
`default_nettype none
module tube_ring_mesh_sweep #(
  parameter int MAX_SIDES        = 16,
  parameter int MAX_VERTICES     = 65536,
  parameter int ANGLE_TABLE_BITS = 10
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire        [3:0]   paddr,
  input  wire        [31:0]  pwdata,
  output logic       [31:0]  prdata,
  output logic               pready,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire signed [31:0]  pos_x,
  input  wire signed [31:0]  pos_y,
  input  wire signed [31:0]  pos_z,
  input  wire signed [15:0]  normal_x,
  input  wire signed [15:0]  normal_y,
  input  wire signed [15:0]  normal_z,
  input  wire signed [15:0]  binormal_x,
  input  wire signed [15:0]  binormal_y,
  input  wire signed [15:0]  binormal_z,
  input  wire        [31:0]  path_distance,
  input  wire                new_mesh,
  output logic               out_valid,
  input  wire                out_stall,
  output logic       [1:0]   kind,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [15:0] surf_nx,
  output logic signed [15:0] surf_ny,
  output logic signed [15:0] surf_nz,
  output logic       [31:0]  tex_u,
  output logic       [16:0]  tex_v,
  output logic       [15:0]  tri_a,
  output logic       [31:0]  tri_bc,
  output logic               last
);
  import trms_pkg::*;

  logic [4:0]  side_count;
  logic [15:0] radius_mm;
  logic        facing_inward;
  logic        clear_prev;
  logic        cfg_wr;
  logic [4:0]  sides_next;
  logic [1:0]  reg_idx;

  logic        q_full;
  logic        q_push;
  job_t        q_in;
  logic        q_pop;
  job_t        q_head;
  logic        q_valid;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // clamp the side count
  always_comb begin
    if (pwdata[4:0] < 5'd3) begin
      sides_next = 5'd3;
    end else if (32'(pwdata[4:0]) > MAX_SIDES) begin
      sides_next = 5'(MAX_SIDES);
    end else begin
      sides_next = pwdata[4:0];
    end
  end

  // a changed side count breaks the strip at the write edge
  assign clear_prev = cfg_wr && (reg_idx == REG_SIDES) && (sides_next != side_count);

  // register read
  always_comb begin
    unique case (reg_idx)
      REG_SIDES:  prdata = 32'(side_count);
      REG_RADIUS: prdata = 32'(radius_mm);
      REG_FACING: prdata = 32'(facing_inward);
      default:    prdata = '0;
    endcase
  end

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      side_count    <= 5'd8;
      radius_mm     <= 16'd1000;
      facing_inward <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_SIDES:  side_count    <= sides_next;
          REG_RADIUS: radius_mm     <= pwdata[15:0];
          REG_FACING: facing_inward <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  trms_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .binormal_x   (binormal_x),
    .binormal_y   (binormal_y),
    .binormal_z   (binormal_z),
    .path_distance(path_distance),
    .new_mesh     (new_mesh),
    .side_count   (side_count),
    .clear_prev   (clear_prev),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_in)
  );

  trms_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .not_empty(q_valid)
  );

  trms_back #(
    .ANGLE_TABLE_BITS(ANGLE_TABLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_job        (q_head),
    .q_pop        (q_pop),
    .side_count   (side_count),
    .radius_mm    (radius_mm),
    .facing_inward(facing_inward),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .surf_nx      (surf_nx),
    .surf_ny      (surf_ny),
    .surf_nz      (surf_nz),
    .tex_u        (tex_u),
    .tex_v        (tex_v),
    .tri_a        (tri_a),
    .tri_bc       (tri_bc),
    .last         (last)
  );

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the tube ring mesh sweep: drives path frames and APB writes,
// predicts ring vertices, triangles and budget errors, and checks every output word.
// Depends on trms_pkg and tube_ring_mesh_sweep.
`timescale 1ns / 1ps
module testbench;
  import trms_pkg::*;

  localparam int MAX_SIDES    = 16;
  localparam int MAX_VERTICES = 65536;
  localparam int ANGLE_BITS   = 10;
  localparam int IDLE_LIMIT   = 5000;
  localparam int SETTLE       = 40;
  localparam logic [3:0] ADDR_UNUSED = 4'd12;

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic signed [15:0] bx, by, bz;
    logic [31:0]        arc_len;
    logic               fresh;
  } frame_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] x, y, z;
    logic signed [15:0] nx, ny, nz;
    logic [31:0]        u;
    logic [16:0]        v;
    logic [15:0]        a;
    logic [31:0]        bc;
    logic               last;
  } word_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 0;
  logic        in_stall;
  frame_t      drv = '0;
  logic        out_valid;
  logic        out_stall = 0;
  word_t       got;

  // mirrored registers and strip state
  int unsigned sides_q, radius_q, inward_q;
  int unsigned vcount, prev_base;
  bit          have_prev;

  word_t ring_words[$];
  int    mismatches = 0;
  int    idle_cycles = 0;
  bit    stall_on = 1;
  bit    gaps_on = 1;
  int    stall_left = 0;
  bit    stall_hold = 0;

  always #4 clk = ~clk;

  tube_ring_mesh_sweep u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .pos_x(drv.px), .pos_y(drv.py), .pos_z(drv.pz),
    .normal_x(drv.nx), .normal_y(drv.ny), .normal_z(drv.nz),
    .binormal_x(drv.bx), .binormal_y(drv.by), .binormal_z(drv.bz),
    .path_distance(drv.arc_len), .new_mesh(drv.fresh),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(got.kind), .out_x(got.x), .out_y(got.y), .out_z(got.z),
    .surf_nx(got.nx), .surf_ny(got.ny), .surf_nz(got.nz),
    .tex_u(got.u), .tex_v(got.v), .tri_a(got.a), .tri_bc(got.bc), .last(got.last)
  );

  // cos and sin of a table index, Q1.14, from truncated Taylor series in Q30
  task automatic ring_trig(input int unsigned idx, output longint c, output longint s);
    bit [63:0] x, x2, t, s30, one;
    longint    c30, cq, sq;
    int        sdiv[5];
    int        cdiv[5];
    sdiv = '{110, 72, 42, 20, 6};
    cdiv = '{132, 90, 56, 30, 12};
    one = 64'd1 << 30;
    x  = (64'(idx & 255) * 64'd1686629713) >> 8;
    x2 = (x * x) >> 30;
    t = one;
    for (int i = 0; i < 5; i++) t = one - ((x2 * t) >> 30) / sdiv[i];
    s30 = (x * t) >> 30;
    t = one;
    for (int i = 0; i < 5; i++) t = one - ((x2 * t) >> 30) / cdiv[i];
    c30 = longint'(one) - longint'(((x2 * t) >> 30) / 2);
    if (c30 < 0) c30 = 0;
    sq = longint'((s30 + 64'd32768) >> 16);
    cq = (c30 + 32768) >>> 16;
    case ((idx >> 8) & 3)
      0: begin c = cq;  s = sq;  end
      1: begin c = -sq; s = cq;  end
      2: begin c = -cq; s = -sq; end
      default: begin c = sq; s = -cq; end
    endcase
  endtask

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // predict the words of one accepted frame
  task automatic predict_ring(input frame_t f);
    word_t       w;
    longint      c, s, r, off, mag, nv, p;
    longint      pos[3], nv3[3], bv3[3];
    int unsigned n, base, idx, a, an, b, bn;
    n = sides_q;
    pos = '{f.px, f.py, f.pz};
    nv3 = '{f.nx, f.ny, f.nz};
    bv3 = '{f.bx, f.by, f.bz};
    if (f.fresh) begin
      vcount = 0;
      prev_base = 0;
      have_prev = 0;
    end
    if (vcount + n + 1 > MAX_VERTICES) begin
      w = '0;
      w.kind = KIND_ERR;
      w.last = 1;
      ring_words = {ring_words, w};
      return;
    end
    base = vcount;
    for (int unsigned sd = 0; sd <= n; sd++) begin
      w = '0;
      idx = (sd == n) ? 0 : (((sd << ANGLE_BITS) + n / 2) / n) & ((1 << ANGLE_BITS) - 1);
      ring_trig(idx, c, s);
      for (int i = 0; i < 3; i++) begin
        r = nv3[i] * c + bv3[i] * s;
        mag = r < 0 ? -r : r;
        off = (mag * radius_q + 2048000) / 4096000;
        if (r < 0) off = -off;
        p = clamp(pos[i] + off, -64'sd2147483648, 64'sd2147483647);
        nv = (r + 8192) >>> 14;
        if (inward_q) nv = -nv;
        nv = clamp(nv, -32768, 32767);
        case (i)
          0: begin w.x = p[31:0]; w.nx = nv[15:0]; end
          1: begin w.y = p[31:0]; w.ny = nv[15:0]; end
          default: begin w.z = p[31:0]; w.nz = nv[15:0]; end
        endcase
      end
      w.kind = KIND_VERT;
      w.u = f.arc_len;
      w.v = ((sd << 16) + n / 2) / n;
      ring_words = {ring_words, w};
    end
    vcount = base + n + 1;
    // join to the previous ring, winding by facing
    if (have_prev) begin
      for (int unsigned sd = 0; sd < n; sd++) begin
        a  = (prev_base + sd) & 16'hFFFF;
        an = (a + 1) & 16'hFFFF;
        b  = (base + sd) & 16'hFFFF;
        bn = (b + 1) & 16'hFFFF;
        w = '0;
        w.kind = KIND_TRI;
        w.a = a;
        w.bc = inward_q ? {b[15:0], bn[15:0]} : {bn[15:0], b[15:0]};
        ring_words = {ring_words, w};
        w.bc = inward_q ? {bn[15:0], an[15:0]} : {an[15:0], bn[15:0]};
        ring_words = {ring_words, w};
      end
    end
    prev_base = base & 16'hFFFF;
    have_prev = 1;
    ring_words[$].last = 1;
  endtask

  // check each output word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (ring_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %h", got);
      end else begin
        if (got !== ring_words[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: expected %h actual %h", ring_words[0], got);
        end
        void'(ring_words.pop_front());
      end
    end
  end

  // receiver stall: bursts, mostly short, a few long
  always @(posedge clk) begin
    if (!stall_on) begin
      out_stall <= 0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_hold = $urandom_range(0, 99) < 35;
      out_stall <= stall_hold;
      if ($urandom_range(0, 99) < 5) stall_left <= $urandom_range(15, 50);
      else stall_left <= $urandom_range(0, 3);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (!gaps_on || pick < 60) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // present one frame until accepted, then predict its words
  task automatic send_frame(input frame_t f);
    int gap;
    in_valid <= 1;
    drv <= f;
    do @(posedge clk); while (in_stall);
    predict_ring(f);
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (ring_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write: setup, access, release
  task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
    int unsigned nsides;
    drain();
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (addr[3:2])
      REG_SIDES: begin
        nsides = data[4:0];
        if (nsides < 3) nsides = 3;
        if (nsides > MAX_SIDES) nsides = MAX_SIDES;
        if (nsides != sides_q) have_prev = 0;
        sides_q = nsides;
      end
      REG_RADIUS: radius_q = data[15:0];
      REG_FACING: inward_q = data[0];
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] unit_comp();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'($urandom);
    if (pick == 1) return ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic signed [31:0] pos_comp();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_0000 + 32'($urandom_range(0, 65535));
      1: return 32'h8000_0000 + 32'($urandom_range(0, 65535));
      2, 3: return 32'($urandom);
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic frame_t random_frame(input bit fresh);
    frame_t f;
    f.px = pos_comp(); f.py = pos_comp(); f.pz = pos_comp();
    f.nx = unit_comp(); f.ny = unit_comp(); f.nz = unit_comp();
    f.bx = unit_comp(); f.by = unit_comp(); f.bz = unit_comp();
    f.arc_len = $urandom;
    f.fresh = fresh;
    return f;
  endfunction

  function automatic frame_t axis_frame(input logic signed [31:0] p,
                                        input logic signed [15:0] n,
                                        input logic [31:0] d, input bit fresh);
    frame_t f;
    f = '0;
    f.px = p; f.py = p; f.pz = p;
    f.nx = n; f.bz = n;
    f.arc_len = d;
    f.fresh = fresh;
    return f;
  endfunction

  // default registers, first ring and a short strip
  task automatic test_defaults();
    send_frame(axis_frame(0, 16384, 0, 1));
    send_frame(axis_frame(32'sh0001_0000, 16384, 32'h0001_0000, 0));
    send_frame(random_frame(0));
  endtask

  // field extremes: saturated positions and normals, full-scale vectors
  task automatic test_extremes();
    frame_t f;
    send_frame(axis_frame(32'sh7FFF_FFFF, 16384, 32'hFFFF_FFFF, 0));
    send_frame(axis_frame(32'sh8000_0000, -16384, 32'h0, 0));
    f = '1;
    f.px = 32'sh7FFF_FFFF; f.py = 32'sh8000_0000; f.pz = 0;
    f.nx = 16'sh7FFF; f.ny = 16'sh8000; f.nz = 16'sh7FFF;
    f.bx = 16'sh7FFF; f.by = 16'sh7FFF; f.bz = 16'sh8000;
    f.fresh = 0;
    send_frame(f);
    f.fresh = 1;
    send_frame(f);
  endtask

  // side count clamping, unchanged writes and the unused register address
  task automatic test_side_counts();
    reg_write(4'(REG_SIDES) << 2, 32'd0);
    send_frame(random_frame(0));
    send_frame(random_frame(0));
    reg_write(4'(REG_SIDES) << 2, 32'd2);
    send_frame(random_frame(0));
    reg_write(4'(REG_SIDES) << 2, 32'd31);
    send_frame(random_frame(0));
    reg_write(4'(REG_SIDES) << 2, 32'd17);
    send_frame(random_frame(0));
    reg_write(4'(REG_SIDES) << 2, 32'hFFFF_FFE5);
    send_frame(random_frame(0));
    send_frame(random_frame(0));
    reg_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    send_frame(random_frame(0));
  endtask

  // zero and full radius, inward facing
  task automatic test_radius_facing();
    reg_write(4'(REG_RADIUS) << 2, 32'd0);
    send_frame(random_frame(0));
    reg_write(4'(REG_RADIUS) << 2, 32'hFFFF_FFFF);
    reg_write(4'(REG_FACING) << 2, 32'hFFFF_FFFF);
    send_frame(random_frame(0));
    send_frame(random_frame(0));
    reg_write(4'(REG_FACING) << 2, 32'd0);
    reg_write(4'(REG_RADIUS) << 2, 32'd1);
    send_frame(random_frame(0));
  endtask

  // long 16-sided strip back to back with no stalls, side change, then restart
  task automatic test_budget();
    stall_on = 0;
    gaps_on = 0;
    reg_write(4'(REG_SIDES) << 2, 32'd16);
    send_frame(random_frame(1));
    for (int i = 1; i < 12; i++) send_frame(random_frame(0));
    send_frame(random_frame(0));
    reg_write(4'(REG_SIDES) << 2, 32'd3);
    send_frame(random_frame(0));
    send_frame(random_frame(1));
    stall_on = 1;
    gaps_on = 1;
  endtask

  // mostly continuing strips under changing registers, some restarts
  task automatic test_random();
    for (int i = 0; i < 170; i++) begin
      if (i % 40 == 39) begin
        reg_write(4'(REG_SIDES) << 2, $urandom_range(0, 31));
        reg_write(4'(REG_RADIUS) << 2, ($urandom_range(0, 3) == 0) ? $urandom
                                                                   : $urandom_range(1, 3000));
        reg_write(4'(REG_FACING) << 2, $urandom_range(0, 1));
      end
      if (i >= 80 && i < 110) stall_on = 0;
      else stall_on = 1;
      send_frame(random_frame($urandom_range(0, 9) == 0));
    end
  endtask

  initial begin
    sides_q = 8;
    radius_q = 1000;
    inward_q = 0;
    vcount = 0;
    prev_base = 0;
    have_prev = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_defaults();
    test_extremes();
    test_side_counts();
    test_radius_facing();
    test_budget();
    test_random();
    drain();
    if (mismatches == 0 && ring_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/trms_pkg.sv
rtl/core/trms_front.sv
rtl/core/trms_queue.sv
rtl/core/trms_back.sv
rtl/core/tube_ring_mesh_sweep.sv
verif/testbench.sv
